// File: rtl/core/lzwc_pkg.sv
// LZW compressor package: code widths, dictionary types, sequencer states
// and the bucket hash. No dependencies.

package lzwc_pkg;

  localparam int CODE_W     = 16;              // code width, 9..16
  localparam int SYM_W      = 8;               // symbol width
  localparam int KEY_W      = CODE_W + SYM_W;  // (prefix, byte) pair
  localparam int NEXT_W     = CODE_W + 1;      // next code counter, can hold the full space
  localparam int DICT_DEPTH = 1 << CODE_W;
  localparam int LITERALS   = 1 << SYM_W;
  localparam int CODE_SPACE = 1 << CODE_W;
  localparam int OUT_W      = 16;              // emitted code field

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [NEXT_W-1:0] next_t;
  typedef logic [SYM_W-1:0]  sym_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_PROBE,
    ST_EMIT,
    ST_FINAL
  } st_e;

  // Fold the pair key into a bucket index: prefix xor byte in the top bits.
  function automatic code_t pair_hash(key_t key);
    return key[KEY_W-1:SYM_W] ^ (code_t'(key[SYM_W-1:0]) << (CODE_W - SYM_W));
  endfunction

endpackage

// File: rtl/core/lzw_compressor.sv
// LZW compressor top level: byte stream in, fixed-width code stream out.
// Holds the dictionary memories and the probe sequencer; uses lzwc_pkg.
//
//   channel | dir | tdata                     | tlast
//   --------+-----+---------------------------+-------------------------
//   s_      | in  | [7:0] data_byte           | end_of_stream
//   m_      | out | [15:0] code               | last_code
//
// Steps: the first byte of a stream only becomes the prefix. Every later
// byte is hashed and its bucket head read, then each entry in its hash chain
// is probed in turn; a miss ends in an emit step that sends the prefix and
// inserts the pair while there is room, and a stream end adds a final step
// for the last code. Probes are serialised by the single read port of the
// pair memory, which every probe goes through.
// Reset clears the sequencer, the counters and the output valid flag. The
// dictionary memories are never swept: a bucket or chain pointer counts only
// if it names a code below the next free code whose entry hashes back to
// that bucket, so a new stream starts with an empty dictionary at once.
// A stalled m_ side holds the code in the output register; the emit and
// final steps wait there, and s_tready_o stays low until the byte is done.

module lzw_compressor
  import lzwc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // input byte stream
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [SYM_W-1:0] s_tdata_i,    // [7:0] data_byte
  input  logic             s_tlast_i,    // end_of_stream
  // output code stream
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [OUT_W-1:0] m_tdata_o,    // [15:0] code
  output logic             m_tlast_o     // last_code
);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  st_e   state_q, state_d;
  code_t prefix_q, prefix_d;
  logic  pvalid_q, pvalid_d;
  next_t next_q, next_d;
  code_t cand_q, cand_d;      // code under probe
  sym_t  byte_q;
  logic  last_q;
  code_t hash_q;
  code_t head_q;              // raw bucket head, becomes the new entry's link

  logic  out_valid_q, out_valid_d;
  code_t out_code_q, out_code_d;
  logic  out_last_q, out_last_d;

  // ---------------------------------------------------------------------------
  // Dictionary memories: bucket heads, pair entries, chain links
  // ---------------------------------------------------------------------------
  code_t bh_mem  [DICT_DEPTH];
  key_t  tbl_mem [DICT_DEPTH];
  code_t lnk_mem [DICT_DEPTH];

  code_t bh_rd_q;
  key_t  tbl_rd_q;
  code_t lnk_rd_q;

  logic  bh_re, tbl_re, ins_we;
  code_t bh_raddr, tbl_raddr;

  logic  accept;
  logic  out_free;
  logic  out_load;
  key_t  key;
  code_t new_code;
  logic  room;

  assign accept   = s_tvalid_i && s_tready_o;
  assign out_free = !out_valid_q || m_tready_i;
  assign key      = {prefix_q, byte_q};
  assign new_code = next_q[CODE_W-1:0];
  assign room     = next_q < NEXT_W'(CODE_SPACE);

  always_ff @(posedge clk_i) begin
    if (bh_re) begin
      bh_rd_q <= bh_mem[bh_raddr];
    end
    if (ins_we) begin
      bh_mem[hash_q] <= new_code;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_re) begin
      tbl_rd_q <= tbl_mem[tbl_raddr];
      lnk_rd_q <= lnk_mem[tbl_raddr];
    end
    if (ins_we) begin
      tbl_mem[new_code] <= key;
      lnk_mem[new_code] <= head_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prefix_q    <= '0;
      pvalid_q    <= 1'b0;
      next_q      <= NEXT_W'(LITERALS);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prefix_q    <= prefix_d;
      pvalid_q    <= pvalid_d;
      next_q      <= next_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    cand_q     <= cand_d;
    out_code_q <= out_code_d;
    out_last_q <= out_last_d;
    if (accept) begin
      byte_q <= s_tdata_i;
      last_q <= s_tlast_i;
      hash_q <= pair_hash({prefix_q, s_tdata_i});
    end
    if (state_q == ST_HEAD) begin
      head_q <= bh_rd_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    prefix_d   = prefix_q;
    pvalid_d   = pvalid_q;
    next_d     = next_q;
    cand_d     = cand_q;
    out_load   = 1'b0;
    out_code_d = out_code_q;
    out_last_d = out_last_q;
    bh_re      = 1'b0;
    bh_raddr   = pair_hash({prefix_q, s_tdata_i});
    tbl_re     = 1'b0;
    tbl_raddr  = bh_rd_q;
    ins_we     = 1'b0;
    s_tready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          if (!pvalid_q) begin
            // first byte of a stream becomes the prefix
            prefix_d = code_t'(s_tdata_i);
            pvalid_d = 1'b1;
            state_d  = s_tlast_i ? ST_FINAL : ST_IDLE;
          end else begin
            bh_re   = 1'b1;
            state_d = ST_HEAD;
          end
        end
      end

      ST_HEAD: begin
        // head counts only if it names a live pair code
        if (bh_rd_q >= code_t'(LITERALS) && {1'b0, bh_rd_q} < next_q) begin
          tbl_re    = 1'b1;
          tbl_raddr = bh_rd_q;
          cand_d    = bh_rd_q;
          state_d   = ST_PROBE;
        end else begin
          state_d = ST_EMIT;
        end
      end

      ST_PROBE: begin
        if (tbl_rd_q == key) begin
          // hit: the prefix grows
          prefix_d = cand_q;
          state_d  = last_q ? ST_FINAL : ST_IDLE;
        end else if (pair_hash(tbl_rd_q) == hash_q && lnk_rd_q >= code_t'(LITERALS)
                     && lnk_rd_q < cand_q) begin
          // walk the chain toward older entries
          tbl_re    = 1'b1;
          tbl_raddr = lnk_rd_q;
          cand_d    = lnk_rd_q;
        end else begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_code_d = prefix_q;
          out_last_d = 1'b0;
          if (room) begin
            ins_we = 1'b1;
            next_d = next_q + NEXT_W'(1);
          end
          prefix_d = code_t'(byte_q);
          state_d  = last_q ? ST_FINAL : ST_IDLE;
        end
      end

      ST_FINAL: begin
        if (out_free) begin
          // flush the prefix and restart the dictionary
          out_load   = 1'b1;
          out_code_d = prefix_q;
          out_last_d = 1'b1;
          next_d     = NEXT_W'(LITERALS);
          prefix_d   = '0;
          pvalid_d   = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = OUT_W'(out_code_q);
  assign m_tlast_o  = out_last_q;

endmodule

// File: rtl/core/lzwc_chk.sv
// Port-level checker for the LZW compressor, bound to lzw_compressor.
// Depends on lzwc_pkg for the field widths.

module lzwc_chk
  import lzwc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_tvalid_i,
  input logic             s_tready_i,
  input logic             s_tlast_i,
  input logic             m_tvalid_i,
  input logic             m_tready_i,
  input logic [OUT_W-1:0] m_tdata_i,
  input logic             m_tlast_i
);

  // a stalled code transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tlast_i))
    else $error("stalled output transaction changed");

  // the last byte of a stream always needs the flush step
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i && s_tlast_i |=> !s_tready_i)
    else $error("ready right after the last byte");

  // no code is shown once reset has been seen at an edge
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_tvalid_i)
    else $error("output valid during reset");

endmodule

bind lzw_compressor lzwc_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_i (s_tready_o),
  .s_tlast_i  (s_tlast_i),
  .m_tvalid_i (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_i  (m_tdata_o),
  .m_tlast_i  (m_tlast_o)
);
